### hdl/soa_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the zero-wait walk function for the sonar sequencer.
// No dependencies; every other file in hdl/ imports this package.
package soa_pkg;

    localparam int CAPTURE_WIDTH_DEF = 16;
    localparam int COUNT_WIDTH_DEF   = 16;
    localparam int CFG_ADDR_WIDTH    = 5;
    localparam int SERVO_WIDTH       = 15;
    // enough steps to get from the stop state back around to go
    localparam int WALK_STEPS        = 7;

    // register indexes
    localparam logic [2:0] REG_CLEAR_WIDTH  = 3'd0;
    localparam logic [2:0] REG_TURN_TIME    = 3'd1;
    localparam logic [2:0] REG_SERVO_SETTLE = 3'd2;
    localparam logic [2:0] REG_LOOK_LEFT    = 3'd3;
    localparam logic [2:0] REG_SERVO_LEFT   = 3'd4;
    localparam logic [2:0] REG_SERVO_RIGHT  = 3'd5;
    localparam logic [2:0] REG_SERVO_MIDDLE = 3'd6;

    localparam logic [15:0] CLEAR_WIDTH_RESET  = 16'd580;
    localparam logic [14:0] TURN_TIME_RESET    = 15'd200;
    localparam logic [15:0] SERVO_SETTLE_RESET = 16'd250;
    localparam logic [15:0] LOOK_LEFT_RESET    = 16'd300;
    localparam logic [14:0] SERVO_LEFT_RESET   = 15'd2000;
    localparam logic [14:0] SERVO_RIGHT_RESET  = 15'd600;
    localparam logic [14:0] SERVO_MIDDLE_RESET = 15'd1200;

    // input actions
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_RISE = 2'd1;
    localparam logic [1:0] ACT_FALL = 2'd2;

    // sequencer states
    localparam logic [2:0] ST_GO     = 3'd0;
    localparam logic [2:0] ST_STOP   = 3'd1;
    localparam logic [2:0] ST_TRYR   = 3'd2;
    localparam logic [2:0] ST_TURNR  = 3'd3;
    localparam logic [2:0] ST_TRYL   = 3'd4;
    localparam logic [2:0] ST_TURNL  = 3'd5;
    localparam logic [2:0] ST_AROUND = 3'd6;

    // sub-phases
    localparam logic [2:0] SP_PH0 = 3'd0;
    localparam logic [2:0] SP_PH1 = 3'd1;
    localparam logic [2:0] SP_PH2 = 3'd2;
    localparam logic [2:0] SP_PH3 = 3'd3;

    // motor commands
    localparam logic [1:0] M_BRAKE = 2'd0;
    localparam logic [1:0] M_FWD   = 2'd1;
    localparam logic [1:0] M_RIGHT = 2'd2;
    localparam logic [1:0] M_LEFT  = 2'd3;

    // servo target select
    localparam logic [1:0] SRV_MIDDLE = 2'd0;
    localparam logic [1:0] SRV_LEFT   = 2'd1;
    localparam logic [1:0] SRV_RIGHT  = 2'd2;

    // wait source select
    localparam logic [1:0] WAIT_SETTLE = 2'd0;
    localparam logic [1:0] WAIT_TURN   = 2'd1;
    localparam logic [1:0] WAIT_LOOK   = 2'd2;
    localparam logic [1:0] WAIT_TURN2  = 2'd3;

    typedef struct packed {
        logic [15:0] clear_width_us;
        logic [14:0] turn_time_ms;
        logic [15:0] servo_settle_ms;
        logic [15:0] look_left_wait_ms;
        logic [14:0] servo_left_us;
        logic [14:0] servo_right_us;
        logic [14:0] servo_middle_us;
    } cfg_t;

    typedef struct packed {
        logic [2:0] st;
        logic [2:0] sp;
    } pos_t;

    typedef struct packed {
        logic z_settle;
        logic z_turn;
        logic z_look;
        logic z_turn2;
        logic clear;
    } flags_t;

    typedef struct packed {
        pos_t       pos;
        logic       at_go;
        logic       rest;
        logic       motor_set;
        logic [1:0] motor;
        logic       servo_set;
        logic [1:0] servo_sel;
        logic [1:0] wait_sel;
    } walk_t;

    typedef struct packed {
        logic [1:0]             motor_cmd;
        logic [SERVO_WIDTH-1:0] servo_pulse_us;
        logic                   led_clear;
        logic [2:0]             seq_state;
    } result_t;

    // Runs immediate actions from start until a nonzero wait is armed or
    // the go decision point is reached. Later servo/motor writes win.
    function automatic walk_t walk(pos_t start, flags_t f);
        walk_t r;
        logic  zero_wait;
        r         = '0;
        zero_wait = 1'b1;
        r.pos     = start;
        r.at_go   = (start.st == ST_GO) && (start.sp == SP_PH0);
        for (int i = 0; i < WALK_STEPS; i++) begin
            if (!r.at_go && !r.rest) begin
                zero_wait = 1'b1;
                unique case (r.pos.st) inside
                    ST_GO: begin
                        r.pos.sp = SP_PH0;
                    end
                    ST_STOP: begin
                        r.servo_set = 1'b1;
                        r.servo_sel = SRV_RIGHT;
                        r.wait_sel  = WAIT_SETTLE;
                        zero_wait   = f.z_settle;
                        r.pos       = {ST_TRYR, SP_PH0};
                    end
                    ST_TRYR: begin
                        r.servo_set = 1'b1;
                        r.wait_sel  = WAIT_SETTLE;
                        zero_wait   = f.z_settle;
                        if (f.clear) begin
                            r.servo_sel = SRV_MIDDLE;
                            r.pos       = {ST_TURNR, SP_PH0};
                        end else begin
                            r.servo_sel = SRV_LEFT;
                            r.pos       = {ST_TRYL, SP_PH0};
                        end
                    end
                    ST_TURNR: begin
                        if (r.pos.sp == SP_PH0) begin
                            r.motor_set = 1'b1;
                            r.motor     = M_RIGHT;
                            r.wait_sel  = WAIT_TURN;
                            zero_wait   = f.z_turn;
                            r.pos.sp    = SP_PH1;
                        end else begin
                            r.pos = {ST_GO, SP_PH0};
                        end
                    end
                    ST_TRYL: begin
                        unique case (r.pos.sp)
                            SP_PH0: begin
                                r.wait_sel = WAIT_LOOK;
                                zero_wait  = f.z_look;
                                r.pos.sp   = SP_PH1;
                            end
                            SP_PH1: begin
                                r.servo_set = 1'b1;
                                r.servo_sel = SRV_MIDDLE;
                                r.wait_sel  = WAIT_SETTLE;
                                zero_wait   = f.z_settle;
                                r.pos.sp    = f.clear ? SP_PH2 : SP_PH3;
                            end
                            SP_PH2: begin
                                r.motor_set = 1'b1;
                                r.motor     = M_LEFT;
                                r.wait_sel  = WAIT_TURN;
                                zero_wait   = f.z_turn;
                                r.pos       = {ST_TURNL, SP_PH0};
                            end
                            default: begin
                                r.motor_set = 1'b1;
                                r.motor     = M_LEFT;
                                r.wait_sel  = WAIT_TURN2;
                                zero_wait   = f.z_turn2;
                                r.pos       = {ST_AROUND, SP_PH0};
                            end
                        endcase
                    end
                    ST_TURNL, ST_AROUND: begin
                        if (r.pos.sp == SP_PH0) begin
                            r.servo_set = 1'b1;
                            r.servo_sel = SRV_MIDDLE;
                            r.wait_sel  = WAIT_SETTLE;
                            zero_wait   = f.z_settle;
                            r.pos.sp    = SP_PH1;
                        end else begin
                            r.pos = {ST_GO, SP_PH0};
                        end
                    end
                    default: begin
                        r.pos = {ST_GO, SP_PH0};
                    end
                endcase
                r.rest  = !zero_wait;
                r.at_go = (r.pos.st == ST_GO) && (r.pos.sp == SP_PH0);
            end
        end
        return r;
    endfunction

endpackage

### hdl/soa_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: event words in, result words out.
// Depends on soa_pkg for the servo field width.
interface soa_evt_if #(
    parameter int CAPTURE_WIDTH = 16
);
    logic                     valid;
    logic                     ready;
    logic [1:0]               action;
    logic [CAPTURE_WIDTH-1:0] capture_time;

    modport source (output valid, output action, output capture_time, input ready);
    modport sink   (input valid, input action, input capture_time, output ready);
endinterface

interface soa_res_if;
    import soa_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [1:0]             motor_cmd;
    logic [SERVO_WIDTH-1:0] servo_pulse_us;
    logic                   led_clear;
    logic [2:0]             seq_state;

    modport source (output valid, output motor_cmd, output servo_pulse_us,
                    output led_clear, output seq_state, input ready);
    modport sink   (input valid, input motor_cmd, input servo_pulse_us,
                    input led_clear, input seq_state, output ready);
endinterface

### hdl/sonar_obstacle_avoid_sequencer.sv
`timescale 1ns / 1ps
// Sonar obstacle-avoidance sequencer, top level.
// Path: a word accepted on evt sits in the input register, then its result moves to
//   the result register once that slot is free; the whole step runs combinationally between them.
// Throughput: one event word per cycle unless res stalls, set by the registered core pass.
// Reset (rst_n, async, active low): config defaults, servo centered, startup settle wait.
// Depends on soa_pkg, soa_if, soa_cfg_regs and soa_seq_core.
module sonar_obstacle_avoid_sequencer #(
    parameter int CAPTURE_WIDTH = soa_pkg::CAPTURE_WIDTH_DEF,
    parameter int COUNT_WIDTH   = soa_pkg::COUNT_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    soa_evt_if.sink                            evt,
    soa_res_if.source                          res,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [soa_pkg::CFG_ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import soa_pkg::*;

    cfg_t                     cfg;
    result_t                  result_next;
    result_t                  res_reg;

    // input register stage
    logic                     in_valid_reg, in_valid_next;
    logic [1:0]               in_action_reg;
    logic [CAPTURE_WIDTH-1:0] in_capture_reg;

    // result register stage
    logic                     res_valid_reg, res_valid_next;

    logic                     evt_take;
    logic                     advance;

    soa_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The core state moves only when a word leaves the input register
    // for the result register, so each word sees the state its
    // predecessor left.
    soa_seq_core #(
        .CAPTURE_WIDTH (CAPTURE_WIDTH),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .step         (advance),
        .action       (in_action_reg),
        .capture_time (in_capture_reg),
        .result_next  (result_next)
    );

    // result slot is free when empty or being drained this cycle
    assign advance   = in_valid_reg && (!res_valid_reg || res.ready);
    assign evt.ready = !in_valid_reg || advance;
    assign evt_take  = evt.valid && evt.ready;

    assign in_valid_next  = evt_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign res_valid_next = advance ? 1'b1 : (res.ready ? 1'b0 : res_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (evt_take)
        begin
            in_action_reg  <= evt.action;
            in_capture_reg <= evt.capture_time;
        end
        if (advance)
        begin
            res_reg <= result_next;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.motor_cmd      = res_reg.motor_cmd;
    assign res.servo_pulse_us = res_reg.servo_pulse_us;
    assign res.led_clear      = res_reg.led_clear;
    assign res.seq_state      = res_reg.seq_state;

endmodule

### hdl/soa_cfg_regs.sv
`timescale 1ns / 1ps
// APB-style configuration register file for the sonar sequencer.
// Depends on soa_pkg for cfg_t, register indexes and reset values.
module soa_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [soa_pkg::CFG_ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output soa_pkg::cfg_t                      cfg
);
    import soa_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[CFG_ADDR_WIDTH-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_CLEAR_WIDTH:  cfg_next.clear_width_us    = pwdata[15:0];
                REG_TURN_TIME:    cfg_next.turn_time_ms      = pwdata[14:0];
                REG_SERVO_SETTLE: cfg_next.servo_settle_ms   = pwdata[15:0];
                REG_LOOK_LEFT:    cfg_next.look_left_wait_ms = pwdata[15:0];
                REG_SERVO_LEFT:   cfg_next.servo_left_us     = pwdata[14:0];
                REG_SERVO_RIGHT:  cfg_next.servo_right_us    = pwdata[14:0];
                REG_SERVO_MIDDLE: cfg_next.servo_middle_us   = pwdata[14:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_CLEAR_WIDTH:  prdata = 32'(cfg_reg.clear_width_us);
            REG_TURN_TIME:    prdata = 32'(cfg_reg.turn_time_ms);
            REG_SERVO_SETTLE: prdata = 32'(cfg_reg.servo_settle_ms);
            REG_LOOK_LEFT:    prdata = 32'(cfg_reg.look_left_wait_ms);
            REG_SERVO_LEFT:   prdata = 32'(cfg_reg.servo_left_us);
            REG_SERVO_RIGHT:  prdata = 32'(cfg_reg.servo_right_us);
            REG_SERVO_MIDDLE: prdata = 32'(cfg_reg.servo_middle_us);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clear_width_us    <= CLEAR_WIDTH_RESET;
            cfg_reg.turn_time_ms      <= TURN_TIME_RESET;
            cfg_reg.servo_settle_ms   <= SERVO_SETTLE_RESET;
            cfg_reg.look_left_wait_ms <= LOOK_LEFT_RESET;
            cfg_reg.servo_left_us     <= SERVO_LEFT_RESET;
            cfg_reg.servo_right_us    <= SERVO_RIGHT_RESET;
            cfg_reg.servo_middle_us   <= SERVO_MIDDLE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/soa_seq_core.sv
`timescale 1ns / 1ps
// Sequencer state and single-pass next-state logic for one event word.
// Depends on soa_pkg (walk function, codes, cfg_t, result_t).
module soa_seq_core #(
    parameter int CAPTURE_WIDTH = soa_pkg::CAPTURE_WIDTH_DEF,
    parameter int COUNT_WIDTH   = soa_pkg::COUNT_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  soa_pkg::cfg_t            cfg,
    input  logic                     step,
    input  logic [1:0]               action,
    input  logic [CAPTURE_WIDTH-1:0] capture_time,
    output soa_pkg::result_t         result_next
);
    import soa_pkg::*;

    localparam int DW = ((CAPTURE_WIDTH > 16) ? CAPTURE_WIDTH : 16) + 2;
    localparam logic [COUNT_WIDTH-1:0] CNT_RESET = COUNT_WIDTH'(SERVO_SETTLE_RESET);

    pos_t                     pos_reg, pos_next;
    logic [COUNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic [CAPTURE_WIDTH-1:0] start_reg, start_next;
    logic [CAPTURE_WIDTH-1:0] stop_reg, stop_next;
    logic                     measured_reg, measured_next;
    logic                     led_reg, led_next;
    logic [1:0]               motor_reg, motor_next;
    logic [SERVO_WIDTH-1:0]   servo_reg, servo_next;

    logic signed [DW-1:0]     echo_width;
    logic                     path_clear;
    logic [COUNT_WIDTH-1:0]   cnt_tick;
    logic [31:0]              settle_32, turn_32, turn2_32, look_32;
    logic [COUNT_WIDTH-1:0]   w_settle, w_turn, w_turn2, w_look;
    flags_t                   flags;
    walk_t                    walk_a, walk_b;

    function automatic logic [COUNT_WIDTH-1:0] wait_of(logic [1:0] sel);
        logic [COUNT_WIDTH-1:0] v;
        unique case (sel)
            WAIT_SETTLE: v = w_settle;
            WAIT_TURN:   v = w_turn;
            WAIT_LOOK:   v = w_look;
            default:     v = w_turn2;
        endcase
        return v;
    endfunction

    function automatic logic [SERVO_WIDTH-1:0] servo_of(logic [1:0] sel);
        logic [SERVO_WIDTH-1:0] v;
        unique case (sel)
            SRV_LEFT:  v = cfg.servo_left_us;
            SRV_RIGHT: v = cfg.servo_right_us;
            default:   v = cfg.servo_middle_us;
        endcase
        return v;
    endfunction

    // captures land before the width test
    assign start_next    = (action == ACT_RISE) ? capture_time : start_reg;
    assign stop_next     = (action == ACT_FALL) ? capture_time : stop_reg;
    assign measured_next = measured_reg || (action == ACT_FALL);
    assign echo_width    = $signed(DW'(stop_next)) - $signed(DW'(start_next));
    assign path_clear    = echo_width > $signed(DW'(cfg.clear_width_us));
    assign led_next      = (action == ACT_FALL) ? path_clear : led_reg;

    assign cnt_tick = ((action == ACT_TICK) && (cnt_reg != '0)) ?
                      cnt_reg - COUNT_WIDTH'(1) : cnt_reg;

    // wait lengths wrap to the countdown width
    assign settle_32 = 32'(cfg.servo_settle_ms);
    assign turn_32   = 32'(cfg.turn_time_ms);
    assign turn2_32  = {16'd0, cfg.turn_time_ms, 1'b0};
    assign look_32   = 32'(cfg.look_left_wait_ms);
    assign w_settle  = settle_32[COUNT_WIDTH-1:0];
    assign w_turn    = turn_32[COUNT_WIDTH-1:0];
    assign w_turn2   = turn2_32[COUNT_WIDTH-1:0];
    assign w_look    = look_32[COUNT_WIDTH-1:0];

    assign flags.z_settle = (w_settle == '0);
    assign flags.z_turn   = (w_turn == '0);
    assign flags.z_look   = (w_look == '0);
    assign flags.z_turn2  = (w_turn2 == '0);
    assign flags.clear    = path_clear;

    // walk_a from the current spot; walk_b is the second lap after a
    // blocked go decision, always starting at stop
    assign walk_a = walk(pos_reg, flags);
    assign walk_b = walk({ST_STOP, SP_PH0}, flags);

    always_comb
    begin
        pos_next   = pos_reg;
        motor_next = motor_reg;
        servo_next = servo_reg;
        cnt_next   = cnt_tick;
        if (cnt_tick == '0)
        begin
            pos_next = walk_a.pos;
            if (walk_a.motor_set)
            begin
                motor_next = walk_a.motor;
            end
            if (walk_a.servo_set)
            begin
                servo_next = servo_of(walk_a.servo_sel);
            end
            if (walk_a.rest)
            begin
                cnt_next = wait_of(walk_a.wait_sel);
            end
            if (walk_a.at_go)
            begin
                if (measured_next && path_clear)
                begin
                    motor_next = M_FWD;
                end
                else
                begin
                    motor_next = M_BRAKE;
                    servo_next = cfg.servo_middle_us;
                    pos_next   = {ST_STOP, SP_PH0};
                    if (!flags.z_settle)
                    begin
                        cnt_next = w_settle;
                    end
                    else
                    begin
                        // go already decided: walk_b ends resting or at go
                        pos_next = walk_b.pos;
                        if (walk_b.motor_set)
                        begin
                            motor_next = walk_b.motor;
                        end
                        if (walk_b.servo_set)
                        begin
                            servo_next = servo_of(walk_b.servo_sel);
                        end
                        if (walk_b.rest)
                        begin
                            cnt_next = wait_of(walk_b.wait_sel);
                        end
                    end
                end
            end
        end
    end

    assign result_next.motor_cmd      = motor_next;
    assign result_next.servo_pulse_us = servo_next;
    assign result_next.led_clear      = led_next;
    assign result_next.seq_state      = pos_next.st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= {ST_GO, SP_PH1};
            cnt_reg      <= CNT_RESET;
            start_reg    <= '0;
            stop_reg     <= '0;
            measured_reg <= 1'b0;
            led_reg      <= 1'b0;
            motor_reg    <= M_BRAKE;
            servo_reg    <= SERVO_MIDDLE_RESET;
        end
        else if (step)
        begin
            pos_reg      <= pos_next;
            cnt_reg      <= cnt_next;
            start_reg    <= start_next;
            stop_reg     <= stop_next;
            measured_reg <= measured_next;
            led_reg      <= led_next;
            motor_reg    <= motor_next;
            servo_reg    <= servo_next;
        end
    end

    a_wait_holds: assert property (@(posedge clk) disable iff (!rst_n)
        step && (action != ACT_TICK) && (cnt_reg != '0) |=>
            $stable(pos_reg) && $stable(cnt_reg) && $stable(motor_reg) && $stable(servo_reg))
        else $error("sequencer moved without a tick while a wait was pending");

    a_no_step_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(pos_reg) && $stable(cnt_reg) && $stable(led_reg))
        else $error("sequencer state changed with no event word");

    a_fwd_in_go: assert property (@(posedge clk) disable iff (!rst_n)
        (motor_reg == M_FWD) |-> (pos_reg.st == ST_GO))
        else $error("forward drive outside go state");

    a_go_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg.st == ST_GO) && (pos_reg.sp == SP_PH0) |-> (cnt_reg == '0))
        else $error("pending wait while resting in go");

endmodule
